FILE: sv/sensor_min_max_calibrate_normalize_macros.svh
// assertion macros for the sensor calibration block
`ifndef SENSOR_MIN_MAX_CALIBRATE_NORMALIZE_MACROS_SVH
`define SENSOR_MIN_MAX_CALIBRATE_NORMALIZE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SMM_ASSERT_NOW(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define SMM_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define SMM_ASSERT_NOW(label, clk, rst_n, a, b)
`define SMM_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

FILE: sv/smm_pkg.sv
// types and constants shared by the sensor calibration block
package smm_pkg;

    localparam int SMP_W     = 8;
    localparam int DIV_W     = 16;
    localparam int DIV_CNT_W = 5;

    localparam logic [2:0] MODE_START  = 3'd0;
    localparam logic [2:0] MODE_SAMPLE = 3'd1;
    localparam logic [2:0] MODE_FINISH = 3'd2;
    localparam logic [2:0] MODE_LOAD   = 3'd3;
    localparam logic [2:0] MODE_READ   = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_CH  = 2'd1;
    localparam logic [1:0] ST_DEGEN   = 2'd2;

    localparam logic [1:0] REG_LEVEL_TOP = 2'd0;
    localparam logic [1:0] REG_LOW_DIV   = 2'd1;
    localparam logic [1:0] REG_HIGH_DIV  = 2'd2;

    typedef struct packed {
        logic [2:0]       mode;
        logic [3:0]       channel;
        logic [SMP_W-1:0] sample_a;
        logic [SMP_W-1:0] sample_b;
        logic [SMP_W-1:0] load_low;
        logic [SMP_W-1:0] load_high;
    } cmd_t;

    typedef struct packed {
        logic [3:0]       out_channel;
        logic [7:0]       level;
        logic [7:0]       low_threshold;
        logic [7:0]       high_threshold;
        logic [1:0]       status;
        logic             last;
    } res_t;

    typedef struct packed {
        logic             go;
        logic [DIV_W-1:0] dividend;
        logic [SMP_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

FILE: sv/smm_div.sv
// serial restoring divider, one quotient bit per cycle
module smm_div
    import smm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [DIV_W-1:0]     qd_reg, qd_next;
    logic [SMP_W-1:0]     rem_reg, rem_next;
    logic [SMP_W-1:0]     dvs_reg, dvs_next;
    logic [SMP_W:0]       sh;
    logic                 ge;

    always_comb
    begin
        sh        = {rem_reg, qd_reg[DIV_W-1]};
        ge        = sh >= {1'b0, dvs_reg};
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        qd_next   = qd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.go)
        begin
            cnt_next = DIV_CNT_W'(DIV_W);
            qd_next  = req.dividend;
            rem_next = '0;
            dvs_next = req.divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = ge ? SMP_W'(sh - {1'b0, dvs_reg}) : sh[SMP_W-1:0];
            qd_next   = {qd_reg[DIV_W-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qd_reg  <= qd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = qd_reg;

endmodule

FILE: sv/sensor_min_max_calibrate_normalize.sv
// top level of the per-channel sensor calibration and normalisation block
//
// Commands enter on cmd, taken at a clock edge with start high and busy low.
// Results leave on result, each shown for one cycle with result_valid high;
// the receiver cannot stall, so every result must be taken when shown.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 level top, 1 low trim
// divisor, 2 high trim divisor) and cfg_data; cfg_ready is always high.
// Start, sample, load, reads of degenerate or invalid channels: the result
// appears the cycle after the item, and the next item may follow at once.
// A good read takes two multiply and divide passes, one per sample.
// Finish gives one result per channel in order, the last marked by last.
// The cost per division is set by the shared 16-step serial divider.
// Reset returns registers to their defaults, running minima to all ones,
// running maxima and stored thresholds to zero, and busy low.
`include "sensor_min_max_calibrate_normalize_macros.svh"
module sensor_min_max_calibrate_normalize
    import smm_pkg::*;
#(
    parameter int NUM_CHANNELS = 14
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  cmd_t       cmd,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output logic       result_valid,
    output res_t       result
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [CH_W-1:0] LAST_IDX = CH_W'(NUM_CHANNELS - 1);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_FIN_DIV  = 3'd1;
    localparam logic [2:0] S_FIN_WAIT = 3'd2;
    localparam logic [2:0] S_RD_MUL   = 3'd3;
    localparam logic [2:0] S_RD_DIV   = 3'd4;
    localparam logic [2:0] S_RD_WAIT  = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [CH_W-1:0]  ch_reg, ch_next;
    logic             phase_reg, phase_next;
    logic [SMP_W-1:0] sa_reg, sa_next, sb_reg, sb_next;
    logic [SMP_W-1:0] q1_reg, q1_next;
    logic [DIV_W-1:0] prod_reg, prod_next;
    logic             res_valid_reg, res_valid_next;
    res_t             res_reg, res_next;
    logic [7:0]       top_reg, top_next, ldiv_reg, ldiv_next, hdiv_reg, hdiv_next;

    logic [SMP_W-1:0] min_reg [NUM_CHANNELS];
    logic [SMP_W-1:0] min_next [NUM_CHANNELS];
    logic [SMP_W-1:0] max_reg [NUM_CHANNELS];
    logic [SMP_W-1:0] max_next [NUM_CHANNELS];
    logic [SMP_W-1:0] lo_reg [NUM_CHANNELS];
    logic [SMP_W-1:0] lo_next [NUM_CHANNELS];
    logic [SMP_W-1:0] hi_reg [NUM_CHANNELS];
    logic [SMP_W-1:0] hi_next [NUM_CHANNELS];

    logic             acc, ok;
    logic [CH_W-1:0]  in_idx;
    logic [SMP_W-1:0] in_lo, in_hi, mn, mx, rg, dl, dh, c_lo, c_hi, v, vc;
    logic [SMP_W-1:0] new_lo, new_hi;
    logic [SMP_W:0]   sum;
    div_req_t         dreq;
    div_rsp_t         drsp;

    smm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign acc       = start && !busy;
    assign ok        = 32'(cmd.channel) < NUM_CHANNELS;
    assign in_idx    = cmd.channel[CH_W-1:0];
    assign in_lo     = lo_reg[in_idx];
    assign in_hi     = hi_reg[in_idx];
    assign mn        = min_reg[ch_reg];
    assign mx        = max_reg[ch_reg];
    assign rg        = (mx >= mn) ? (mx - mn) : '0;
    assign dl        = (ldiv_reg == '0) ? 8'd1 : ldiv_reg;
    assign dh        = (hdiv_reg == '0) ? 8'd1 : hdiv_reg;
    assign c_lo      = lo_reg[ch_reg];
    assign c_hi      = hi_reg[ch_reg];
    assign v         = phase_reg ? sb_reg : sa_reg;
    assign vc        = (v < c_lo) ? c_lo : ((v > c_hi) ? c_hi : v);
    assign new_lo    = mn + q1_reg;
    assign new_hi    = mx - drsp.quotient[SMP_W-1:0];
    assign sum       = {1'b0, q1_reg} + {1'b0, drsp.quotient[SMP_W-1:0]};

    always_comb
    begin
        dreq.go       = 1'b0;
        dreq.dividend = {8'd0, rg};
        dreq.divisor  = phase_reg ? dh : dl;
        unique case (state_reg)
            S_FIN_DIV:
            begin
                dreq.go = 1'b1;
            end
            S_RD_DIV:
            begin
                dreq.go       = 1'b1;
                dreq.dividend = prod_reg;
                dreq.divisor  = c_hi - c_lo;
            end
            default:
            begin
                dreq.go = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        phase_next     = phase_reg;
        sa_next        = sa_reg;
        sb_next        = sb_reg;
        q1_next        = q1_reg;
        prod_next      = prod_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        top_next       = top_reg;
        ldiv_next      = ldiv_reg;
        hdiv_next      = hdiv_reg;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_LEVEL_TOP: top_next  = cfg_data;
                REG_LOW_DIV:   ldiv_next = cfg_data;
                REG_HIGH_DIV:  hdiv_next = cfg_data;
                default:       top_next  = top_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    ch_next    = in_idx;
                    sa_next    = cmd.sample_a;
                    sb_next    = cmd.sample_b;
                    phase_next = 1'b0;
                    res_next   = '{cmd.channel, 8'd0, 8'd0, 8'd0, ST_BAD_CH, 1'b1};
                    if (cmd.mode == MODE_START)
                    begin
                        for (int i = 0; i < NUM_CHANNELS; i++)
                        begin
                            min_next[i] = '1;
                            max_next[i] = '0;
                        end
                    end
                    if (cmd.mode == MODE_FINISH)
                    begin
                        ch_next    = '0;
                        state_next = S_FIN_DIV;
                    end
                    else if (cmd.mode <= MODE_READ)
                    begin
                        res_valid_next = 1'b1;
                        if (ok)
                        begin
                            res_next = '{cmd.channel, 8'd0, in_lo, in_hi, ST_OK, 1'b1};
                            if (cmd.mode == MODE_SAMPLE)
                            begin
                                if (cmd.sample_a < min_reg[in_idx])
                                    min_next[in_idx] = cmd.sample_a;
                                if (cmd.sample_a > max_reg[in_idx])
                                    max_next[in_idx] = cmd.sample_a;
                            end
                            else if (cmd.mode == MODE_LOAD)
                            begin
                                lo_next[in_idx] = cmd.load_low;
                                hi_next[in_idx] = cmd.load_high;
                                res_next.low_threshold  = cmd.load_low;
                                res_next.high_threshold = cmd.load_high;
                                res_next.status = (cmd.load_high > cmd.load_low) ?
                                                  ST_OK : ST_DEGEN;
                            end
                            else if (cmd.mode == MODE_READ)
                            begin
                                if (in_hi <= in_lo)
                                    res_next.status = ST_DEGEN;
                                else
                                begin
                                    res_valid_next = 1'b0;
                                    state_next     = S_RD_MUL;
                                end
                            end
                        end
                    end
                end
            end
            S_FIN_DIV:
            begin
                state_next = S_FIN_WAIT;
            end
            S_FIN_WAIT:
            begin
                if (drsp.done)
                begin
                    if (!phase_reg)
                    begin
                        q1_next    = drsp.quotient[SMP_W-1:0];
                        phase_next = 1'b1;
                        state_next = S_FIN_DIV;
                    end
                    else
                    begin
                        lo_next[ch_reg] = new_lo;
                        hi_next[ch_reg] = new_hi;
                        res_valid_next  = 1'b1;
                        res_next = '{4'(ch_reg), 8'd0, new_lo, new_hi,
                                     (new_hi > new_lo) ? ST_OK : ST_DEGEN,
                                     ch_reg == LAST_IDX};
                        phase_next = 1'b0;
                        if (ch_reg == LAST_IDX)
                            state_next = S_IDLE;
                        else
                        begin
                            ch_next    = ch_reg + 1'b1;
                            state_next = S_FIN_DIV;
                        end
                    end
                end
            end
            S_RD_MUL:
            begin
                prod_next  = {8'd0, vc - c_lo} * {8'd0, top_reg};
                state_next = S_RD_DIV;
            end
            S_RD_DIV:
            begin
                state_next = S_RD_WAIT;
            end
            S_RD_WAIT:
            begin
                if (drsp.done)
                begin
                    if (!phase_reg)
                    begin
                        q1_next    = drsp.quotient[SMP_W-1:0];
                        phase_next = 1'b1;
                        state_next = S_RD_MUL;
                    end
                    else
                    begin
                        res_valid_next = 1'b1;
                        res_next = '{4'(ch_reg), sum[SMP_W:1], c_lo, c_hi, ST_OK, 1'b1};
                        phase_next = 1'b0;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
            top_reg       <= 8'd30;
            ldiv_reg      <= 8'd4;
            hdiv_reg      <= 8'd10;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                min_reg[i] <= '1;
                max_reg[i] <= '0;
                lo_reg[i]  <= '0;
                hi_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            res_valid_reg <= res_valid_next;
            top_reg       <= top_next;
            ldiv_reg      <= ldiv_next;
            hdiv_reg      <= hdiv_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg   <= ch_next;
        sa_reg   <= sa_next;
        sb_reg   <= sb_next;
        q1_reg   <= q1_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    `SMM_ASSERT_NEXT(a_finish_busy, clk, rst_n, acc && cmd.mode == MODE_FINISH, busy)
    `SMM_ASSERT_NOW(a_last_idle, clk, rst_n, result_valid && result.last, !busy)
    `SMM_ASSERT_NOW(a_more_busy, clk, rst_n, result_valid && !result.last, busy)

endmodule

FILE: tb/tb_top.sv
// self-checking testbench for the sensor calibration and normalisation block
`timescale 1ns / 1ps
module tb_top;
    import smm_pkg::*;

    localparam int NCH = 14;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    cmd_t       cmd;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;
    logic       result_valid;
    res_t       result;

    sensor_min_max_calibrate_normalize #(.NUM_CHANNELS(NCH)) uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .result_valid(result_valid), .result(result)
    );

    logic [7:0] lvl_top, div_lo, div_hi;
    logic [7:0] run_min [NCH];
    logic [7:0] run_max [NCH];
    logic [7:0] thr_lo [NCH];
    logic [7:0] thr_hi [NCH];
    res_t       pending_res [$];
    int         errors = 0;

    typedef struct {
        cmd_t c;
        bit   typed;
        res_t r;
    } row_t;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    initial
    begin
        #50ms;
        $display("simulation failed");
        $finish;
    end

    function automatic res_t mk(logic [3:0] ch, logic [7:0] lv, logic [7:0] lo,
                                logic [7:0] hi, logic [1:0] st, logic la);
        res_t r;
        r.out_channel = ch; r.level = lv; r.low_threshold = lo;
        r.high_threshold = hi; r.status = st; r.last = la;
        return r;
    endfunction

    function automatic int scale_one(int v, int lo, int hi);
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        return ((v - lo) * int'(lvl_top)) / (hi - lo);
    endfunction

    task automatic predict_cmd(cmd_t c);
        int ch, mn, mx, rg, dl, dh, s;
        ch = int'(c.channel);
        if (c.mode > MODE_READ)
            return;
        if (c.mode == MODE_FINISH)
        begin
            dl = (div_lo == 0) ? 1 : int'(div_lo);
            dh = (div_hi == 0) ? 1 : int'(div_hi);
            for (int i = 0; i < NCH; i++)
            begin
                mn = int'(run_min[i]); mx = int'(run_max[i]);
                rg = (mx >= mn) ? mx - mn : 0;
                thr_lo[i] = 8'(mn + rg / dl);
                thr_hi[i] = 8'(mx - rg / dh);
                pending_res.push_back(mk(4'(i), 8'd0, thr_lo[i], thr_hi[i],
                    thr_hi[i] > thr_lo[i] ? ST_OK : ST_DEGEN, i == NCH - 1));
            end
            return;
        end
        if (c.mode == MODE_START)
            for (int i = 0; i < NCH; i++)
            begin
                run_min[i] = 8'hff; run_max[i] = 8'h00;
            end
        if (ch >= NCH)
            pending_res.push_back(mk(4'(ch), 8'd0, 8'd0, 8'd0, ST_BAD_CH, 1'b1));
        else if (c.mode == MODE_LOAD)
        begin
            thr_lo[ch] = c.load_low; thr_hi[ch] = c.load_high;
            pending_res.push_back(mk(4'(ch), 8'd0, c.load_low, c.load_high,
                c.load_high > c.load_low ? ST_OK : ST_DEGEN, 1'b1));
        end
        else if (c.mode == MODE_READ)
        begin
            if (thr_hi[ch] <= thr_lo[ch])
                pending_res.push_back(mk(4'(ch), 8'd0, thr_lo[ch], thr_hi[ch], ST_DEGEN,
                                         1'b1));
            else
            begin
                s = scale_one(int'(c.sample_a), int'(thr_lo[ch]), int'(thr_hi[ch]))
                  + scale_one(int'(c.sample_b), int'(thr_lo[ch]), int'(thr_hi[ch]));
                pending_res.push_back(mk(4'(ch), 8'(s / 2), thr_lo[ch], thr_hi[ch], ST_OK,
                                         1'b1));
            end
        end
        else
        begin
            if (c.mode == MODE_SAMPLE)
            begin
                if (c.sample_a < run_min[ch]) run_min[ch] = c.sample_a;
                if (c.sample_a > run_max[ch]) run_max[ch] = c.sample_a;
            end
            pending_res.push_back(mk(4'(ch), 8'd0, thr_lo[ch], thr_hi[ch], ST_OK, 1'b1));
        end
    endtask

    always @(posedge clk)
    begin
        res_t e;
        if (rst_n && result_valid)
        begin
            if (pending_res.size() == 0)
            begin
                $error("result with none expected: %p", result);
                errors++;
            end
            else
            begin
                e = pending_res.pop_front();
                if (result.out_channel !== e.out_channel)
                begin
                    $error("out_channel exp %0d got %0d", e.out_channel, result.out_channel);
                    errors++;
                end
                if (result.level !== e.level)
                begin
                    $error("level exp %0d got %0d", e.level, result.level);
                    errors++;
                end
                if (result.low_threshold !== e.low_threshold)
                begin
                    $error("low_threshold exp %0d got %0d", e.low_threshold,
                           result.low_threshold);
                    errors++;
                end
                if (result.high_threshold !== e.high_threshold)
                begin
                    $error("high_threshold exp %0d got %0d", e.high_threshold,
                           result.high_threshold);
                    errors++;
                end
                if (result.status !== e.status)
                begin
                    $error("status exp %0d got %0d", e.status, result.status);
                    errors++;
                end
                if (result.last !== e.last)
                begin
                    $error("last exp %0d got %0d", e.last, result.last);
                    errors++;
                end
            end
        end
    end

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0)
            n = 0;
        if (n != 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic issue(cmd_t c, bit typed, res_t r);
        int before_n;
        cmd   <= c;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        before_n = pending_res.size();
        predict_cmd(c);
        if (typed && pending_res.size() == before_n + 1)
            if (pending_res[before_n] != r)
            begin
                $error("typed row mismatch for mode %0d", c.mode);
                errors++;
            end
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        start <= 1'b0;
        while (pending_res.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_LEVEL_TOP: lvl_top = v;
            REG_LOW_DIV:   div_lo = v;
            default:       div_hi = v;
        endcase
    endtask

    function automatic cmd_t mkc(logic [2:0] m, logic [3:0] ch, logic [7:0] a,
                                 logic [7:0] b, logic [7:0] lo, logic [7:0] hi);
        cmd_t c;
        c.mode = m; c.channel = ch; c.sample_a = a; c.sample_b = b;
        c.load_low = lo; c.load_high = hi;
        return c;
    endfunction

    function automatic cmd_t rand_cmd();
        cmd_t c;
        int   p;
        c = cmd_t'({$urandom, $urandom});
        p = $urandom_range(0, 99);
        if (p < 40) c.mode = MODE_SAMPLE;
        else if (p < 70) c.mode = MODE_READ;
        else if (p < 82) c.mode = MODE_LOAD;
        else if (p < 87) c.mode = MODE_FINISH;
        else if (p < 91) c.mode = MODE_START;
        else c.mode = 3'($urandom_range(5, 7));
        if ($urandom_range(0, 9) != 0)
            c.channel = 4'($urandom_range(0, NCH - 1));
        if (c.mode == MODE_LOAD && $urandom_range(0, 3) != 0 && c.load_low > c.load_high)
            {c.load_low, c.load_high} = {c.load_high, c.load_low};
        return c;
    endfunction

    initial
    begin
        row_t dir [$];
        cmd_t c;
        lvl_top = 30; div_lo = 4; div_hi = 10;
        for (int i = 0; i < NCH; i++)
        begin
            run_min[i] = 8'hff; run_max[i] = 0; thr_lo[i] = 0; thr_hi[i] = 0;
        end
        rst_n = 1'b0; start = 1'b0; cmd = '0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        dir.push_back('{mkc(MODE_SAMPLE, 0, 0, 0, 0, 0), 1, mk(0, 0, 0, 0, ST_OK, 1)});
        dir.push_back('{mkc(MODE_READ, 3, 8'hff, 0, 0, 0), 1, mk(3, 0, 0, 0, ST_DEGEN, 1)});
        dir.push_back('{mkc(MODE_READ, 15, 1, 1, 0, 0), 1, mk(15, 0, 0, 0, ST_BAD_CH, 1)});
        dir.push_back('{mkc(MODE_SAMPLE, 14, 9, 0, 0, 0), 1, mk(14, 0, 0, 0, ST_BAD_CH, 1)});
        dir.push_back('{mkc(MODE_LOAD, 15, 0, 0, 1, 2), 1, mk(15, 0, 0, 0, ST_BAD_CH, 1)});
        dir.push_back('{mkc(MODE_START, 15, 0, 0, 0, 0), 1, mk(15, 0, 0, 0, ST_BAD_CH, 1)});
        dir.push_back('{mkc(MODE_START, 2, 0, 0, 0, 0), 1, mk(2, 0, 0, 0, ST_OK, 1)});
        dir.push_back('{mkc(MODE_LOAD, 13, 0, 0, 0, 8'hff), 1, mk(13, 0, 0, 8'hff, ST_OK, 1)});
        dir.push_back('{mkc(MODE_LOAD, 1, 0, 0, 8'hff, 0), 1, mk(1, 0, 8'hff, 0, ST_DEGEN, 1)});
        dir.push_back('{mkc(MODE_LOAD, 4, 0, 0, 50, 50), 1, mk(4, 0, 50, 50, ST_DEGEN, 1)});
        dir.push_back('{mkc(MODE_READ, 13, 0, 8'hff, 0, 0), 1, mk(13, 15, 0, 8'hff, ST_OK, 1)});
        dir.push_back('{mkc(MODE_READ, 13, 8'hff, 8'hff, 0, 0), 1, mk(13, 30, 0, 8'hff, ST_OK, 1)});
        dir.push_back('{mkc(MODE_READ, 4, 7, 7, 0, 0), 1, mk(4, 0, 50, 50, ST_DEGEN, 1)});
        dir.push_back('{mkc(MODE_SAMPLE, 5, 8'hff, 0, 0, 0), 0, '0});
        dir.push_back('{mkc(MODE_SAMPLE, 5, 8'h00, 0, 0, 0), 0, '0});
        dir.push_back('{mkc(MODE_SAMPLE, 6, 8'haa, 0, 0, 0), 0, '0});
        dir.push_back('{mkc(MODE_SAMPLE, 7, 8'h55, 0, 0, 0), 0, '0});
        dir.push_back('{mkc(MODE_SAMPLE, 7, 8'h80, 0, 0, 0), 0, '0});
        dir.push_back('{mkc(3'd5, 0, 0, 0, 0, 0), 0, '0});
        dir.push_back('{mkc(3'd7, 15, 8'hff, 8'hff, 8'hff, 8'hff), 0, '0});
        dir.push_back('{mkc(MODE_FINISH, 0, 0, 0, 0, 0), 0, '0});
        dir.push_back('{mkc(MODE_READ, 5, 8'hff, 0, 0, 0), 0, '0});
        dir.push_back('{mkc(MODE_READ, 7, 8'h60, 8'h70, 0, 0), 0, '0});
        dir.push_back('{mkc(MODE_READ, 6, 8'haa, 8'h01, 0, 0), 0, '0});
        foreach (dir[i])
        begin
            issue(dir[i].c, dir[i].typed, dir[i].r);
            idle_gap();
        end

        for (int phase = 0; phase < 5; phase++)
        begin
            drain();
            case (phase)
                0: begin write_reg(REG_LEVEL_TOP, 255); write_reg(REG_LOW_DIV, 1);
                         write_reg(REG_HIGH_DIV, 255); end
                1: begin write_reg(REG_LEVEL_TOP, 1); write_reg(REG_LOW_DIV, 255);
                         write_reg(REG_HIGH_DIV, 1); end
                2: begin write_reg(REG_LEVEL_TOP, 0); write_reg(REG_LOW_DIV, 0);
                         write_reg(REG_HIGH_DIV, 0); end
                default: begin write_reg(REG_LEVEL_TOP, 8'($urandom_range(1, 255)));
                         write_reg(REG_LOW_DIV, 8'($urandom_range(1, 255)));
                         write_reg(REG_HIGH_DIV, 8'($urandom_range(1, 255))); end
            endcase
            cfg_valid <= 1'b0;
            for (int k = 0; k < 52; k++)
            begin
                c = rand_cmd();
                issue(c, 0, '0);
                idle_gap();
            end
        end

        drain();
        if (errors == 0 && pending_res.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+sv
sv/smm_pkg.sv
sv/smm_div.sv
sv/sensor_min_max_calibrate_normalize.sv
tb/tb_top.sv
